FILE: rtl/biquad_iir_audio_filter_top_defines.svh
// assertion macros shared by the biquad filter rtl
`ifndef BIQUAD_IIR_AUDIO_FILTER_TOP_DEFINES_SVH
`define BIQUAD_IIR_AUDIO_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BIQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/biq_pkg.sv
// shared constants and types for the biquad filter
package biq_pkg;

  // number of filter coefficients and width of the register index
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  // coefficient register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

endpackage

FILE: rtl/biq_coef_regs.sv
// coefficient register file written through the configuration port
module biq_coef_regs
  import biq_pkg::*;
#(
  parameter int COEF_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [COEF_WIDTH-1:0]                cfg_data,
  output logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs
);

  // unity gain in q4 format
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

  logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r[COEF_B0] <= COEF_ONE;
      coefs_r[COEF_B1] <= '0;
      coefs_r[COEF_B2] <= '0;
      coefs_r[COEF_A1] <= '0;
      coefs_r[COEF_A2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        COEF_B0: coefs_r[COEF_B0] <= cfg_data;
        COEF_B1: coefs_r[COEF_B1] <= cfg_data;
        COEF_B2: coefs_r[COEF_B2] <= cfg_data;
        COEF_A1: coefs_r[COEF_A1] <= cfg_data;
        COEF_A2: coefs_r[COEF_A2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coefs = coefs_r;

endmodule

FILE: rtl/biq_core.sv
// biquad arithmetic: history registers, products, sum, rounding and clamp
module biq_core
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  logic [SAMPLE_WIDTH-1:0]              x,
  input  logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs,
  output logic [SAMPLE_WIDTH-1:0]              y,
  output logic                                 clip
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + 3;
  localparam int FRAC   = COEF_WIDTH - 4;
  localparam int RES_W  = ACC_W - FRAC;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC - 1);
  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] prev_in_one_r, prev_in_two_r;
  logic signed [SAMPLE_WIDTH-1:0] prev_out_one_r, prev_out_two_r;
  logic signed [PROD_W-1:0]       p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_sh;
  logic        [RES_W-1:0]        res;
  logic                           over_hi, over_lo;

  // five independent products
  assign p_b0 = $signed(x)              * $signed(coefs[COEF_B0]);
  assign p_b1 = prev_in_one_r           * $signed(coefs[COEF_B1]);
  assign p_b2 = prev_in_two_r           * $signed(coefs[COEF_B2]);
  assign p_a1 = prev_out_one_r          * $signed(coefs[COEF_A1]);
  assign p_a2 = prev_out_two_r          * $signed(coefs[COEF_A2]);

  // exact sum with half-lsb rounding bias
  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;
  assign acc_sh = acc >>> FRAC;
  assign res    = acc_sh[RES_W-1:0];

  // clamp to the sample range when the upper bits are not a sign copy
  assign over_hi = !res[RES_W-1] && (res[RES_W-2:SAMPLE_WIDTH-1] != '0);
  assign over_lo =  res[RES_W-1] && (res[RES_W-2:SAMPLE_WIDTH-1] != '1);

  always_comb begin
    if (over_hi) begin
      y = SMAX;
    end else if (over_lo) begin
      y = SMIN;
    end else begin
      y = res[SAMPLE_WIDTH-1:0];
    end
  end

  assign clip = over_hi || over_lo;

  // history shifts once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_one_r  <= '0;
      prev_in_two_r  <= '0;
      prev_out_one_r <= '0;
      prev_out_two_r <= '0;
    end else if (step) begin
      prev_in_two_r  <= prev_in_one_r;
      prev_in_one_r  <= $signed(x);
      prev_out_two_r <= prev_out_one_r;
      prev_out_one_r <= $signed(y);
    end
  end

endmodule

FILE: rtl/biquad_iir_audio_filter_top.sv
// top level of the biquad filter: handshake stages around the filter core
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | in_sample_in, in_buffer_end_in
//   out     | out_valid/out_ready  | out_sample_out, out_buffer_end_out, out_clipped
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one word per cycle while the output is not stalled; out_valid rises after the input
// accept once the word has passed the input register and the result register
// around the combinational multiply-add-round-clamp path, which closes the
// output feedback loop.
// synchronous active-low reset clears the handshake stages and the history;
// coefficients return to unity pass-through.
// a stalled output holds its word and the input stage fills behind it.
`include "biquad_iir_audio_filter_top_defines.svh"

module biquad_iir_audio_filter_top
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input word
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                    in_buffer_end_in,
  // result word
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                    out_buffer_end_out,
  output logic                    out_clipped,
  // coefficient writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COEF_WIDTH-1:0]   cfg_data
);

  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                                 in_valid_r;
  logic [SAMPLE_WIDTH-1:0]              in_sample_r;
  logic                                 in_buffer_end_r;
  logic                                 out_valid_r;
  logic [SAMPLE_WIDTH-1:0]              out_sample_r;
  logic                                 out_buffer_end_r;
  logic                                 out_clipped_r;
  logic                                 adv;
  logic                                 step;
  logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs;
  logic [SAMPLE_WIDTH-1:0]              y;
  logic                                 clip;

  // stage control: result register frees up when empty or taken
  assign adv      = !out_valid_r || out_ready;
  assign step     = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  // coefficient registers
  biq_coef_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // filter arithmetic and history
  biq_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .x     (in_sample_r),
    .coefs (coefs),
    .y     (y),
    .clip  (clip)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r     <= in_sample_in;
      in_buffer_end_r <= in_buffer_end_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_sample_r     <= y;
      out_buffer_end_r <= in_buffer_end_r;
      out_clipped_r    <= clip;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_buffer_end_out = out_buffer_end_r;
  assign out_clipped        = out_clipped_r;

  // checks
  `BIQ_ASSERT_NEXT(a_hold_pending, in_valid_r && !adv, in_valid_r && $stable(in_sample_r), "pending input word lost")
  `BIQ_ASSERT_NEXT(a_drain_once, out_valid_r && out_ready && !in_valid_r, !out_valid_r, "result word repeated")
  `BIQ_ASSERT_NEXT(a_load_result, step, out_valid_r, "processed word not presented")
  `BIQ_ASSERT_NOW(a_clip_rails, out_valid_r && out_clipped_r, out_sample_r == SMAX || out_sample_r == SMIN, "clipped word not at a rail")

endmodule

FILE: sim/biquad_iir_audio_filter_top_tb.sv
// self-checking testbench for the biquad filter top level with a bit-exact predictor
`timescale 1ns / 1ps

module biquad_iir_audio_filter_top_tb;
  import biq_pkg::*;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 12;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_set_t [NUM_COEFS];
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one filtered word as seen on the result port
  typedef struct packed {
    sample_t sample;
    logic    buffer_end;
    logic    clipped;
  } filt_word_t;

  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t   COEF_UNITY = coef_t'(1) <<< (COEF_W-4);
  localparam coef_t   COEF_HALF  = coef_t'(1) <<< (COEF_W-5);
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample_in = '0;
  logic                  in_buffer_end_in = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample_out;
  logic                  out_buffer_end_out;
  logic                  out_clipped;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0]     cfg_data = '0;

  // filter state as predicted by the testbench
  coef_t   coef_q [NUM_COEFS];
  sample_t hist_in_one, hist_in_two, hist_out_one, hist_out_two;

  filt_word_t pending_words[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;

  biquad_iir_audio_filter_top #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_WIDTH  (COEF_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_buffer_end_in  (in_buffer_end_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_buffer_end_out(out_buffer_end_out),
    .out_clipped       (out_clipped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mismatch reporting
  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // direct-form-I step: exact products, round half up, clamp, update history
  function automatic filt_word_t filter_step(input sample_t x, input logic last);
    longint     acc;
    longint     y;
    longint     smax;
    longint     smin;
    filt_word_t w;
    smax = longint'(SAMPLE_MAX);
    smin = longint'(SAMPLE_MIN);
    acc = longint'(coef_q[COEF_B0]) * longint'(x)
        + longint'(coef_q[COEF_B1]) * longint'(hist_in_one)
        + longint'(coef_q[COEF_B2]) * longint'(hist_in_two)
        - longint'(coef_q[COEF_A1]) * longint'(hist_out_one)
        - longint'(coef_q[COEF_A2]) * longint'(hist_out_two);
    acc = acc + (longint'(1) <<< (COEF_W-5));
    y = acc >>> (COEF_W-4);
    w.clipped = 1'b0;
    if (y > smax) begin
      y = smax;
      w.clipped = 1'b1;
    end else if (y < smin) begin
      y = smin;
      w.clipped = 1'b1;
    end
    w.sample = sample_t'(y);
    w.buffer_end = last;
    hist_in_two = hist_in_one;
    hist_in_one = x;
    hist_out_two = hist_out_one;
    hist_out_one = w.sample;
    return w;
  endfunction

  // send one input word and queue its predicted result
  task automatic send_word(input sample_t s, input logic last);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    in_buffer_end_in <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_words.push_back(filter_step(s, last));
  endtask

  // drop valid and wait until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // one register write, valid is left high for the caller to drop
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_COEFS) coef_q[idx] = coef_t'(val);
  endtask

  // load a full coefficient set once the filter is idle
  task automatic load_coefs(input coef_set_t c);
    wait_drained();
    for (int i = 0; i < NUM_COEFS; i++) write_coef(coef_idx_t'(i), c[i]);
    cfg_valid <= 1'b0;
  endtask

  // mostly full-range samples, some quiet ones, some extremes
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 60) return sample_t'($urandom);
    if (r < 85) return sample_t'($urandom_range(4095) - 2048);
    case ($urandom_range(3))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  // coefficient flavors: 0 full range, 1 mild and stable, 2 corner values
  function automatic coef_t pick_coef(input int kind);
    if (kind == 0) return coef_t'($urandom);
    if (kind == 1) return coef_t'(int'($urandom_range(1 << (COEF_W-4))) - (1 << (COEF_W-5)));
    case ($urandom_range(3))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return COEF_UNITY;
      default: return coef_t'(0);
    endcase
  endfunction

  // audio buffers of random length, end marker on the last word
  task automatic stream_buffers(input int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(16, 1);
      for (int i = 0; i < len; i++) send_word(pick_sample(), i == len - 1);
      sent += len;
    end
  endtask

  // coefficients at reset give unity pass-through
  task automatic test_pass_through();
    send_word(sample_t'(0), 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(sample_t'(1), 1'b0);
    send_word(sample_t'(-1), 1'b1);
    send_word(sample_t'(16'h5555), 1'b0);
    send_word(sample_t'(16'haaaa), 1'b1);
  endtask

  // largest and smallest coefficients drive saturation both ways
  task automatic test_coef_extremes();
    load_coefs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MAX, 1'b1);
    load_coefs('{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN});
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(sample_t'(0), 1'b1);
  endtask

  // gain of one half lands exactly on rounding ties
  task automatic test_round_ties();
    load_coefs('{COEF_HALF, coef_t'(0), coef_t'(0), coef_t'(0), coef_t'(0)});
    send_word(sample_t'(1), 1'b0);
    send_word(sample_t'(-1), 1'b0);
    send_word(sample_t'(3), 1'b0);
    send_word(sample_t'(-3), 1'b1);
  endtask

  // writes to indexes past the last coefficient must be ignored
  task automatic test_unused_index();
    load_coefs('{COEF_UNITY, COEF_HALF, coef_t'(0), COEF_HALF, coef_t'(0)});
    @(posedge clk);
    for (int i = NUM_COEFS; i < (1 << CFG_IDX_W); i++)
      write_coef(CFG_IDX_W'(i), COEF_W'($urandom));
    cfg_valid <= 1'b0;
    send_word(sample_t'(1000), 1'b0);
    send_word(sample_t'(-20000), 1'b0);
    send_word(SAMPLE_MAX, 1'b1);
  endtask

  // random coefficient sets with random buffers behind each
  task automatic test_random_filters();
    coef_set_t c;
    for (int set_n = 0; set_n < 7; set_n++) begin
      for (int i = 0; i < NUM_COEFS; i++) c[i] = pick_coef(set_n % 3);
      load_coefs(c);
      stream_buffers(55);
    end
  endtask

  // long run with no idling on either side
  task automatic test_back_to_back();
    coef_set_t c;
    for (int i = 0; i < NUM_COEFS; i++) c[i] = pick_coef(1);
    load_coefs(c);
    idle_on = 1'b0;
    stream_buffers(110);
    wait_drained();
    idle_on = 1'b1;
  endtask

  // result port back-pressure
  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 35);
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : check_words
    filt_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_error($sformatf("unexpected word: sample %0d", $signed(out_sample_out)));
      end else begin
        want = pending_words.pop_front();
        if (out_sample_out !== want.sample)
          report_error($sformatf("sample_out %0d, predicted %0d",
                                 $signed(out_sample_out), want.sample));
        if (out_buffer_end_out !== want.buffer_end)
          report_error($sformatf("buffer_end_out %b, predicted %b",
                                 out_buffer_end_out, want.buffer_end));
        if (out_clipped !== want.clipped)
          report_error($sformatf("clipped %b, predicted %b (sample %0d)",
                                 out_clipped, want.clipped, want.sample));
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("biquad_iir_audio_filter_top regression: fail");
    $finish;
  end

  // test sequence
  initial begin : run_tests
    coef_q[COEF_B0] = COEF_UNITY;
    coef_q[COEF_B1] = '0;
    coef_q[COEF_B2] = '0;
    coef_q[COEF_A1] = '0;
    coef_q[COEF_A2] = '0;
    hist_in_one = '0;
    hist_in_two = '0;
    hist_out_one = '0;
    hist_out_two = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through();
    test_coef_extremes();
    test_round_ties();
    test_unused_index();
    test_random_filters();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("biquad_iir_audio_filter_top regression: pass");
    end else begin
      $display("biquad_iir_audio_filter_top regression: fail");
    end
    $finish;
  end

endmodule
